// ===== design/fbs_pkg.sv =====
// shared constants, register codes and helpers for the byte stream frame splitter
`timescale 1ns / 1ps

package fbs_pkg;

  // default sizing
  localparam int DEF_BUF_DEPTH = 64;
  localparam int DEF_MARK_MAX  = 8;
  localparam int CMDQ_DEPTH    = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_FIXED_MODE = 3'd1,
    CFG_FRAME_LEN  = 3'd2,
    CFG_MARK_LEN   = 3'd3,
    CFG_MARK_BYTES = 3'd4,
    CFG_MAX_BUFFER = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam logic [6:0] RST_FRAME_LEN  = 7'd1;
  localparam logic [6:0] RST_MAX_BUFFER = 7'd64;

  // width of one command word between front and back:
  // pass flag, pass byte, start slot, length
  function automatic int fbs_cmd_bits(input int depth);
    return 9 + $clog2(depth) + $clog2(depth + 1);
  endfunction

endpackage

// ===== design/fbs_byte_if.sv =====
// input channel carrying one received byte per word
`timescale 1ns / 1ps

interface fbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== design/fbs_frame_if.sv =====
// output channel carrying one frame byte per word
`timescale 1ns / 1ps

interface fbs_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== design/fbs_cfg_if.sv =====
// configuration write channel: register index and write data
`timescale 1ns / 1ps

interface fbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/byte_stream_frame_splitter_top.sv =====
// top level of the byte stream frame splitter
//
//   channel     dir  handshake      payload
//   bytes_ch    in   valid / ready  data_byte[7:0]
//   frames_ch   out  valid / ready  out_byte[7:0], frame_end
//   cfg_ch      in   valid / ready  index[2:0], data[63:0]
//
// a byte that ends no frame, or passes straight through, does not hold intake;
// a byte that completes frames holds intake until its frames are queued
// the back end sends 1 word per cycle, paced by the single store read port,
// when the queue holds commands and the output is not stalled
// rst is synchronous and clears all control state; the byte store is not cleared
// output stalls back up through a 4-entry command queue and slot occupancy
`timescale 1ns / 1ps

module byte_stream_frame_splitter_top #(
  parameter int BUF_DEPTH = fbs_pkg::DEF_BUF_DEPTH,
  parameter int MARK_MAX  = fbs_pkg::DEF_MARK_MAX
) (
  input  logic        clk,
  input  logic        rst,
  fbs_byte_if.sink    bytes_ch,
  fbs_frame_if.source frames_ch,
  fbs_cfg_if.sink     cfg_ch
);
  import fbs_pkg::*;

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int CMD_W = fbs_cmd_bits(BUF_DEPTH);

  logic             q_push;
  logic [CMD_W-1:0] q_wdata;
  logic             q_pop;
  logic [CMD_W-1:0] q_rdata;
  logic             q_full;
  logic             q_empty;
  logic             st_we;
  logic [AW-1:0]    st_addr;
  logic [7:0]       st_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             slot_free;

  // intake and frame detection
  fbs_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .MARK_MAX  (MARK_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes_ch  (bytes_ch),
    .cfg_ch    (cfg_ch),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full),
    .st_we     (st_we),
    .st_addr   (st_addr),
    .st_data   (st_data),
    .slot_free (slot_free)
  );

  // command queue
  fbs_queue #(
    .W     (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // byte store
  fbs_store #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_addr),
    .wr_data (st_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // frame output
  fbs_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .frames_ch (frames_ch)
  );

  // no push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("command pushed into full queue");

  // no pop from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("command popped from empty queue");

  // intake never overwrites a slot that is being read
  a_no_slot_clash: assert property (@(posedge clk) disable iff (rst)
      !(st_we && rd_en && (st_addr == rd_addr)))
    else $error("store write hit the slot being read");

endmodule

// ===== design/fbs_store.sv =====
// frame byte store: one write port, one registered read port
`timescale 1ns / 1ps

module fbs_store #(
  parameter int BUF_DEPTH = fbs_pkg::DEF_BUF_DEPTH
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
  output logic [7:0]                   rd_data
);
  import fbs_pkg::*;

  logic [7:0] mem [BUF_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/fbs_queue.sv =====
// short command queue between the front and the back
`timescale 1ns / 1ps

module fbs_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fbs_pkg::CMDQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  import fbs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [NW-1:0] count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wdata;
    end
  end

endmodule

// ===== design/fbs_front.sv =====
// front end: config registers, byte intake, overflow and frame detection
`timescale 1ns / 1ps

module fbs_front #(
  parameter int BUF_DEPTH = fbs_pkg::DEF_BUF_DEPTH,
  parameter int MARK_MAX  = fbs_pkg::DEF_MARK_MAX
) (
  input  logic                                        clk,
  input  logic                                        rst,
  fbs_byte_if.sink                                    bytes_ch,
  fbs_cfg_if.sink                                     cfg_ch,
  output logic                                        q_push,
  output logic [fbs_pkg::fbs_cmd_bits(BUF_DEPTH)-1:0] q_wdata,
  input  logic                                        q_full,
  output logic                                        st_we,
  output logic [$clog2(BUF_DEPTH)-1:0]                st_addr,
  output logic [7:0]                                  st_data,
  input  logic                                        slot_free
);
  import fbs_pkg::*;

  localparam int AW   = $clog2(BUF_DEPTH);
  localparam int CW   = $clog2(BUF_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam int HW   = CW + 1;

  typedef struct packed {
    logic          pass;
    logic [7:0]    data;
    logic [AW-1:0] start;
    logic [CW-1:0] len;
  } cmd_t;

  typedef enum logic {
    F_IDLE,
    F_EMIT
  } fstate_t;

  // configuration registers
  logic        enable;
  logic        fixed_mode;
  logic [6:0]  frame_len;
  logic [3:0]  mark_len;
  logic [63:0] mark_bytes;
  logic [6:0]  max_buffer;

  // buffer bookkeeping
  fstate_t         state;
  logic [CW-1:0]   fill;
  logic [AW-1:0]   head;
  logic [AW-1:0]   wp;
  logic [CW-1:0]   occ;
  logic [CMPW-1:0] emit_len;
  logic [7:0]      hist [MARK_MAX];

  logic [CMPW-1:0] limit;
  logic [CMPW-1:0] fill_ext;
  logic [CMPW-1:0] fill_new;
  logic [CMPW-1:0] frame_n;
  logic [3:0]      mark_m;
  logic            room;
  logic            need_slot;
  logic            accept;
  logic [7:0]      hist_new [MARK_MAX];
  logic [3:0]      pos;
  logic [7:0]      mark_sel;
  logic            tail_hit;
  logic            delim_hit;
  logic            do_write;
  logic            do_discard;
  logic [CW-1:0]   len_cw;
  logic [CW-1:0]   fill_rem;
  logic [HW-1:0]   head_sum;
  logic [AW-1:0]   head_next;
  logic [CW-1:0]   occ_next;
  cmd_t            cmd;

  // configuration writes, taken at any time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      fixed_mode <= 1'b0;
      frame_len  <= RST_FRAME_LEN;
      mark_len   <= '0;
      mark_bytes <= '0;
      max_buffer <= RST_MAX_BUFFER;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_ENABLE:     enable     <= cfg_ch.data[0];
        CFG_FIXED_MODE: fixed_mode <= cfg_ch.data[0];
        CFG_FRAME_LEN:  frame_len  <= cfg_ch.data[6:0];
        CFG_MARK_LEN:   mark_len   <= cfg_ch.data[3:0];
        CFG_MARK_BYTES: mark_bytes <= cfg_ch.data;
        CFG_MAX_BUFFER: max_buffer <= cfg_ch.data[6:0];
        default: ;
      endcase
    end
  end

  // limits and intake decision
  always_comb begin
    limit     = (CMPW'(max_buffer) > CMPW'(BUF_DEPTH)) ? CMPW'(BUF_DEPTH)
                                                        : CMPW'(max_buffer);
    fill_ext  = CMPW'(fill);
    fill_new  = fill_ext + 1'b1;
    frame_n   = (frame_len == '0) ? CMPW'(1) : CMPW'(frame_len);
    mark_m    = (mark_len > 4'(MARK_MAX)) ? 4'(MARK_MAX) : mark_len;
    room      = (fill_ext < limit);
    need_slot = enable && room;
    bytes_ch.ready = (state == F_IDLE) && !q_full && (!need_slot || (occ < CW'(BUF_DEPTH)));
    accept     = bytes_ch.valid && bytes_ch.ready;
    do_write   = accept && need_slot;
    do_discard = accept && enable && !room;
  end

  // tail compare against the mark, newest byte included
  always_comb begin
    hist_new[0] = bytes_ch.data_byte;
    for (int i = 1; i < MARK_MAX; i++) begin
      hist_new[i] = hist[i-1];
    end
    tail_hit = 1'b1;
    pos      = '0;
    mark_sel = '0;
    for (int k = 0; k < MARK_MAX; k++) begin
      if (4'(k) < mark_m) begin
        pos      = 4'(mark_m - 4'(k) - 4'd1);
        mark_sel = 8'(mark_bytes >> {pos, 3'b000});
        if (hist_new[k] != mark_sel) begin
          tail_hit = 1'b0;
        end
      end
    end
    delim_hit = (mark_m == '0) || ((fill_new >= CMPW'(mark_m)) && tail_hit);
  end

  // frame emission, pass-through commands and head advance
  always_comb begin
    len_cw    = CW'(emit_len);
    fill_rem  = fill - len_cw;
    head_sum  = HW'(head) + HW'(len_cw);
    head_next = (head_sum >= HW'(BUF_DEPTH)) ? AW'(head_sum - HW'(BUF_DEPTH))
                                             : AW'(head_sum);
    cmd       = '0;
    q_push    = 1'b0;
    if (state == F_EMIT) begin
      cmd.start = head;
      cmd.len   = len_cw;
      q_push    = !q_full;
    end else if (accept && !enable) begin
      cmd.pass = 1'b1;
      cmd.data = bytes_ch.data_byte;
      cmd.len  = CW'(1);
      q_push   = 1'b1;
    end
    q_wdata = cmd;
  end

  // slot occupancy: buffered bytes plus bytes queued but not yet read
  always_comb begin
    occ_next = occ + CW'(do_write) - CW'(slot_free) - (do_discard ? fill : '0);
  end

  assign st_we   = do_write;
  assign st_addr = wp;
  assign st_data = bytes_ch.data_byte;

  // control state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      fill     <= '0;
      head     <= '0;
      wp       <= '0;
      occ      <= '0;
      emit_len <= '0;
    end else begin
      occ <= occ_next;
      unique case (state)
        F_IDLE: begin
          if (do_discard) begin
            fill <= '0;
            wp   <= head;
          end else if (do_write) begin
            fill <= CW'(fill_new);
            wp   <= (wp == AW'(BUF_DEPTH - 1)) ? '0 : wp + 1'b1;
            if (fixed_mode) begin
              if (fill_new >= frame_n) begin
                state    <= F_EMIT;
                emit_len <= frame_n;
              end
            end else if (delim_hit) begin
              state    <= F_EMIT;
              emit_len <= fill_new;
            end
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            fill <= fill_rem;
            head <= head_next;
            if (CMPW'(fill_rem) < emit_len) begin
              state <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // recent byte history for the mark compare
  always_ff @(posedge clk) begin
    if (do_write) begin
      for (int i = 0; i < MARK_MAX; i++) begin
        hist[i] <= hist_new[i];
      end
    end
  end

endmodule

// ===== design/fbs_back.sv =====
// back end: runs queued commands, reads frame bytes, drives the output word
`timescale 1ns / 1ps

module fbs_back #(
  parameter int BUF_DEPTH = fbs_pkg::DEF_BUF_DEPTH
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_empty,
  input  logic [fbs_pkg::fbs_cmd_bits(BUF_DEPTH)-1:0] q_rdata,
  output logic                                        q_pop,
  output logic                                        rd_en,
  output logic [$clog2(BUF_DEPTH)-1:0]                rd_addr,
  input  logic [7:0]                                  rd_data,
  output logic                                        slot_free,
  fbs_frame_if.source                                 frames_ch
);
  import fbs_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  typedef struct packed {
    logic          pass;
    logic [7:0]    data;
    logic [AW-1:0] start;
    logic [CW-1:0] len;
  } cmd_t;

  cmd_t          cmd;
  logic          active;
  logic [AW-1:0] rp;
  logic [CW-1:0] remain;

  // read stage
  logic       s1_valid;
  logic       s1_pass;
  logic [7:0] s1_byte;
  logic       s1_end;

  // output register
  logic       out_valid;
  logic [7:0] out_data;
  logic       out_last;

  logic          out_load;
  logic          s1_free;
  logic          take;
  logic [AW-1:0] rp_base;
  logic [AW-1:0] rp_inc;

  // issue control
  always_comb begin
    cmd       = cmd_t'(q_rdata);
    out_load  = !out_valid || frames_ch.ready;
    s1_free   = !s1_valid || out_load;
    take      = s1_free && !active && !q_empty;
    rd_en     = s1_free && (active || (take && !cmd.pass));
    rp_base   = active ? rp : cmd.start;
    rp_inc    = (rp_base == AW'(BUF_DEPTH - 1)) ? '0 : rp_base + 1'b1;
    rd_addr   = rp_base;
    q_pop     = take;
    slot_free = rd_en;
  end

  assign frames_ch.valid     = out_valid;
  assign frames_ch.out_byte  = out_data;
  assign frames_ch.frame_end = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output word
      if (out_load) begin
        out_valid <= s1_valid;
        out_data  <= s1_pass ? s1_byte : rd_data;
        out_last  <= s1_end;
      end
      // read stage: continue a frame, or start the next command
      if (s1_free) begin
        if (active) begin
          s1_valid <= 1'b1;
          s1_pass  <= 1'b0;
          s1_end   <= (remain == CW'(1));
          rp       <= rp_inc;
          remain   <= remain - 1'b1;
          active   <= (remain != CW'(1));
        end else if (!q_empty) begin
          s1_valid <= 1'b1;
          s1_pass  <= cmd.pass;
          s1_byte  <= cmd.data;
          if (cmd.pass) begin
            s1_end <= 1'b1;
          end else begin
            s1_end <= (cmd.len == CW'(1));
            rp     <= rp_inc;
            remain <= cmd.len - 1'b1;
            active <= (cmd.len != CW'(1));
          end
        end else begin
          s1_valid <= 1'b0;
        end
      end
    end
  end

endmodule
